### rtl/core/bpk_pkg.sv
// Types, sizes and width helper shared by the MSB-first bit packer.
// No dependencies; every other file of the packer but bpk_chan_if imports this package.
`default_nettype none

package bpk_pkg;

   localparam int VALUE_BITS = 32;
   localparam int BYTE_BITS  = 8;
   localparam int WIDTH_BITS = 6;
   localparam int PEND_BITS  = 3;
   localparam int WIN_BITS   = VALUE_BITS + BYTE_BITS;
   localparam int CNT_BITS   = 3;
   localparam int Q_DEPTH    = 2;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  flush;
   } req_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last;
   } rsp_type;

   typedef logic [VALUE_BITS-1:0] csr_type;

   typedef struct packed {
      logic [WIN_BITS-1:0] window;
      logic [CNT_BITS-1:0] count;
   } packet_type;

   function automatic logic [WIDTH_BITS-1:0] width_for_max(
      input logic [VALUE_BITS-1:0] m,
      input logic [WIDTH_BITS-1:0] cap
   );
      logic [WIDTH_BITS-1:0] n;
      n = WIDTH_BITS'(1);
      for (int i = 1; i < VALUE_BITS; i++) begin
         if (m[i]) begin
            n = WIDTH_BITS'(i + 1);
         end
      end
      if (n > cap) begin
         n = cap;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

### rtl/core/bpk_chan_if.sv
// Valid/ready channel carrying one payload per transfer.
// Payload type is a parameter; used with the bpk_pkg payload types.
`default_nettype none

interface bpk_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/bpk_front.sv
// Front end: holds the width and the partial byte, aligns each value into a byte window.
// Depends on bpk_pkg; feeds bpk_queue.
`default_nettype none

module bpk_front
   import bpk_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   input  wire csr_type               csr_data,
   input  wire logic                  req_valid,
   input  wire req_type               req_data,
   output logic                       req_ready,
   input  wire logic                  push_ready,
   output logic                       push_valid,
   output packet_type                 push_pkt
);

   localparam int CAP = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;

   logic [WIDTH_BITS-1:0] width_ff, width_in;
   logic [PEND_BITS-1:0]  pend_ff, pend_in;
   logic [BYTE_BITS-1:0]  part_ff, part_in;

   logic                  accept;
   logic [VALUE_BITS:0]   mask_wide;
   logic [VALUE_BITS-1:0] v_masked, v_left;
   logic [WIN_BITS-1:0]   window;
   logic [WIDTH_BITS-1:0] total;
   logic [CNT_BITS-1:0]   full, count;
   logic [PEND_BITS-1:0]  rem;
   logic [BYTE_BITS-1:0]  next_byte;

   always_comb begin
      mask_wide = ~({(VALUE_BITS+1){1'b1}} << width_ff);
      v_masked  = req_data.value & mask_wide[VALUE_BITS-1:0];
      v_left    = v_masked << (WIDTH_BITS'(VALUE_BITS) - width_ff);
      window    = {part_ff, {VALUE_BITS{1'b0}}} | ({v_left, {BYTE_BITS{1'b0}}} >> pend_ff);
      total     = WIDTH_BITS'(pend_ff) + width_ff;
      full      = total[WIDTH_BITS-1:PEND_BITS];
      rem       = total[PEND_BITS-1:0];
      count     = full + CNT_BITS'(req_data.flush && (rem != '0));
      case (full)
         3'd0:    next_byte = window[WIN_BITS-1      -: BYTE_BITS];
         3'd1:    next_byte = window[WIN_BITS-1-8    -: BYTE_BITS];
         3'd2:    next_byte = window[WIN_BITS-1-16   -: BYTE_BITS];
         3'd3:    next_byte = window[WIN_BITS-1-24   -: BYTE_BITS];
         default: next_byte = window[WIN_BITS-1-32   -: BYTE_BITS];
      endcase
   end

   assign req_ready       = push_ready;
   assign accept          = req_valid && req_ready;
   assign push_valid      = accept && (count != '0);
   assign push_pkt.window = window;
   assign push_pkt.count  = count;

   always_comb begin
      width_in = width_ff;
      pend_in  = pend_ff;
      part_in  = part_ff;
      if (csr_valid) begin
         width_in = width_for_max(csr_data, WIDTH_BITS'(CAP));
      end
      if (accept) begin
         if (req_data.flush) begin
            pend_in = '0;
            part_in = '0;
         end else begin
            pend_in = rem;
            part_in = next_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_BITS'(1);
         pend_ff  <= '0;
         part_ff  <= '0;
      end else begin
         width_ff <= width_in;
         pend_ff  <= pend_in;
         part_ff  <= part_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/bpk_queue.sv
// Short register queue of byte windows between front and back end.
// Depends on bpk_pkg for the entry type and depth.
`default_nettype none

module bpk_queue
   import bpk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   input  wire packet_type  push_pkt,
   output logic             push_ready,
   input  wire logic        pop,
   output logic             head_valid,
   output packet_type       head_pkt
);

   localparam int PTR_BITS  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int FILL_BITS = $clog2(Q_DEPTH + 1);

   packet_type            mem_ff [Q_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic                  push_fire, pop_fire;

   assign push_ready = (fill_ff != FILL_BITS'(Q_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_pkt   = mem_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_pkt;
      end
   end

   a_fill_up: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("queue fill did not advance on push");

   a_fill_down: assert property (@(posedge clock) disable iff (reset)
      (pop_fire && !push_fire) |=> (fill_ff == $past(fill_ff) - 1'b1))
      else $error("queue fill did not drop on pop");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_BITS'(Q_DEPTH))
      else $error("queue overfilled");

endmodule

`default_nettype wire

### rtl/core/bpk_back.sv
// Back end: emits the bytes of the head window one per transfer through an output register.
// Depends on bpk_pkg; drains bpk_queue.
`default_nettype none

module bpk_back
   import bpk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        head_valid,
   input  wire packet_type  head_pkt,
   output logic             pop,
   input  wire logic        rsp_ready,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   rsp_type              data_ff, data_in;
   logic                 load, emit, is_last;
   logic [BYTE_BITS-1:0] cur_byte;

   always_comb begin
      case (idx_ff)
         3'd0:    cur_byte = head_pkt.window[WIN_BITS-1    -: BYTE_BITS];
         3'd1:    cur_byte = head_pkt.window[WIN_BITS-1-8  -: BYTE_BITS];
         3'd2:    cur_byte = head_pkt.window[WIN_BITS-1-16 -: BYTE_BITS];
         3'd3:    cur_byte = head_pkt.window[WIN_BITS-1-24 -: BYTE_BITS];
         default: cur_byte = head_pkt.window[WIN_BITS-1-32 -: BYTE_BITS];
      endcase
   end

   assign load    = !valid_ff || rsp_ready;
   assign emit    = load && head_valid;
   assign is_last = (idx_ff == head_pkt.count - 1'b1);
   assign pop     = emit && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = head_valid;
      end
      if (emit) begin
         data_in.out_byte = cur_byte;
         data_in.last     = is_last;
         idx_in           = is_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff < head_pkt.count))
      else $error("byte index past window count");

   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head_pkt.count != '0))
      else $error("empty window reached back end");

endmodule

`default_nettype wire

### rtl/core/bit_packer_msb_first_core.sv
// MSB-first fixed-width bit packer: values in, packed bytes out, one byte per transfer.
// The first byte of an item is registered in the queue entry and then in the output byte register.
// An item causes up to 5 bytes at width 32 with flush, sent one per transfer from the
// single output byte register; a two-entry queue decouples intake from output.
// Reset (synchronous, active high): width 1, no bits pending, queue and output empty.
// Depends on bpk_pkg, bpk_chan_if, bpk_front, bpk_queue and bpk_back.
`default_nettype none

module bit_packer_msb_first_core
   import bpk_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  wire logic     clock,
   input  wire logic     reset,
   bpk_chan_if.sink      req_chan,
   bpk_chan_if.source    rsp_chan,
   bpk_chan_if.sink      csr_chan
);

   logic       push_valid, push_ready, head_valid, pop;
   packet_type push_pkt, head_pkt;
   logic       csr_fire;
   req_type    req_item;
   rsp_type    rsp_item;
   csr_type    csr_item;

   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign csr_item       = csr_chan.data;
   assign req_item       = req_chan.data;

   bpk_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_fire),
      .csr_data   (csr_item),
      .req_valid  (req_chan.valid),
      .req_data   (req_item),
      .req_ready  (req_chan.ready),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_pkt   (push_pkt)
   );

   bpk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_pkt   (push_pkt),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_pkt   (head_pkt)
   );

   bpk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pkt   (head_pkt),
      .pop        (pop),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_data   (rsp_item)
   );

   assign rsp_chan.data = rsp_item;

endmodule

`default_nettype wire

### bench/bit_packer_msb_first_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bit_packer_msb_first_core: drives values and width settings,
// predicts the packed byte stream and checks every byte. Needs bpk_pkg and bpk_chan_if.

module bit_packer_msb_first_core_tb
   import bpk_pkg::*;
;

   localparam int DRAIN_CYCLES = 16;
   localparam int LIMIT_NS     = 5_000_000;

   class packed_stream_check;
      logic [VALUE_BITS-1:0] max_value;
      logic [BYTE_BITS-1:0]  partial;
      int                    pend_count;
      rsp_type               awaited[$];
      int                    values_seen;
      int                    bytes_checked;
      int                    mismatches;

      function new();
         max_value     = 32'd1;
         partial       = '0;
         pend_count    = 0;
         values_seen   = 0;
         bytes_checked = 0;
         mismatches    = 0;
      endfunction

      function int field_width();
         int n;
         n = 1;
         while (n < 32 && ((64'd1 << n) - 64'd1) < {32'd0, max_value}) n++;
         return n;
      endfunction

      function void accept_value(req_type item);
         int         n;
         int         total;
         int         full;
         bit         pad;
         logic [63:0] acc;
         rsp_type    r;
         n     = field_width();
         acc   = {56'd0, partial} >> (8 - pend_count);
         acc   = (acc << n) | ({32'd0, item.value} & ((64'd1 << n) - 64'd1));
         total = pend_count + n;
         full  = total / 8;
         pad   = item.flush && (total % 8 != 0);
         for (int i = 0; i < full; i++) begin
            r.out_byte = 8'(acc >> (total - 8 * (i + 1)));
            r.last     = (i == full - 1) && !pad;
            awaited.push_back(r);
         end
         pend_count = total % 8;
         partial    = 8'(acc << (8 - pend_count));
         if (pad) begin
            r.out_byte = partial;
            r.last     = 1'b1;
            awaited.push_back(r);
            partial    = '0;
            pend_count = 0;
         end
         values_seen++;
      endfunction

      function void check_byte(rsp_type got);
         rsp_type want;
         bytes_checked++;
         if (awaited.size() == 0) begin
            $error("out_byte: expected nothing, got %h (last %b)", got.out_byte, got.last);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpk_chan_if #(.payload_type(req_type)) req_chan ();
   bpk_chan_if #(.payload_type(rsp_type)) rsp_chan ();
   bpk_chan_if #(.payload_type(csr_type)) csr_chan ();

   packed_stream_check board;
   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int writes    = 0;

   bit_packer_msb_first_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         board.check_byte(rsp_chan.data);
      end
   end

   task automatic send_value(input logic [VALUE_BITS-1:0] value, input logic flush);
      req_type item;
      item.value = value;
      item.flush = flush;
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= item;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      board.accept_value(item);
      @(negedge clock);
   endtask

   // hold the sender until every predicted byte has been transferred
   task automatic drain_stream();
      req_chan.valid <= 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_max(input logic [VALUE_BITS-1:0] m);
      drain_stream();
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= m;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      board.max_value = m;
      writes++;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic [VALUE_BITS-1:0] pick_max();
      case ($urandom_range(5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return (32'd1 << $urandom_range(31)) - 32'd1;
         3:       return 32'd1 << $urandom_range(31);
         4:       return $urandom >> $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value(int n);
      logic [VALUE_BITS-1:0] mask;
      mask = 32'((64'd1 << n) - 64'd1);
      case ($urandom_range(4))
         0:       return mask;
         1:       return 32'd0;
         2:       return $urandom & mask;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      #(LIMIT_NS);
      $display("bit_packer_msb_first_core_tb NOT OK");
      $finish;
   end

   initial begin
      board          = new();
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // width 1 from reset, upper bits dropped
      send_value(32'd1, 1'b0);
      send_value(32'd0, 1'b0);
      send_value(32'hFFFF_FFFF, 1'b0);
      send_value(32'd0, 1'b0);
      send_value(32'd1, 1'b0);
      send_value(32'd1, 1'b0);
      send_value(32'd0, 1'b0);
      send_value(32'hFFFF_FFFE, 1'b0);
      send_value(32'd1, 1'b1);
      write_max(32'd0);
      send_value(32'hFFFF_FFFE, 1'b1);
      // leave bits waiting across a width change
      write_max(32'd5);
      send_value(32'd7, 1'b0);
      send_value(32'd0, 1'b0);
      write_max(32'hFFFF_FFFF);
      send_value(32'hFFFF_FFFF, 1'b1);
      send_value(32'd0, 1'b0);
      send_value(32'h8000_0001, 1'b1);
      // flush on a byte boundary: no padding byte
      write_max(32'd255);
      send_value(32'h1A5, 1'b1);
      send_value(32'h3C, 1'b0);
      write_max(32'd256);
      send_value(32'h1FF, 1'b0);
      send_value(32'd0, 1'b1);
      write_max(32'h8000_0000);
      send_value(32'd0, 1'b1);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 88; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 88; end
            default: begin idle_pct = 27; stall_pct = 27; end
         endcase
         for (int k = 0; k < 2; k++) begin
            write_max(pick_max());
            for (int j = 0; j < 36; j++) begin
               send_value(pick_value(board.field_width()), $urandom_range(7) == 0);
            end
         end
      end

      // long receiver hold-off while the sender keeps offering wide values
      idle_pct  = 0;
      stall_pct = 0;
      write_max(32'hFFFF_FFFF);
      hold_left = 400;
      for (int j = 0; j < 24; j++) begin
         send_value($urandom, 1'($urandom_range(1)));
      end
      drain_stream();
      stall_pct = 50;
      for (int j = 0; j < 12; j++) begin
         send_value(pick_value(board.field_width()), $urandom_range(3) == 0);
      end
      drain_stream();

      $display("covered %0d values and %0d packed bytes over %0d width settings,",
               board.values_seen, board.bytes_checked, writes);
      $display("with sender gaps, receiver stalls and a full-queue hold-off");
      if (board.mismatches == 0 && board.awaited.size() == 0) begin
         $display("bit_packer_msb_first_core_tb OK");
      end else begin
         $display("bit_packer_msb_first_core_tb NOT OK");
      end
      $finish;
   end

endmodule
